// ----- rtl/expiring_priority_request_arbiter_top_assert.svh -----
// Assertion helpers for the request arbiter. Both expect clk and arst_n in scope.
`ifndef EXPIRING_PRIORITY_REQUEST_ARBITER_TOP_ASSERT_SVH
`define EXPIRING_PRIORITY_REQUEST_ARBITER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPRA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EPRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/epra_pkg.sv -----
`default_nettype none

package epra_pkg;

	localparam int DEF_SLOTS        = 8;
	localparam int DEF_PATTERN_BITS = 32;

	localparam int OWNER_W    = 16;
	localparam int PRIO_W     = 3;
	localparam int TIME_W     = 32;
	localparam int PORT_PAT_W = 32;
	localparam int CNT_W      = 32;
	localparam int INTERVAL_W = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int EXT_W      = 64;

	localparam logic [INTERVAL_W-1:0] REFRESH_RESET = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFRESH_INTERVAL = 1'b0,
		REG_OFF_PATTERN      = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_SUBMIT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/epra_ram.sv -----
`default_nettype none

module epra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/expiring_priority_request_arbiter_top.sv -----
// Channel   Direction  Handshake            Word
// in        to block   in_valid/in_ready    op, now, owner, priority_req, pattern, expires_at,
//                                           request_active, port_ok
// out       from block out_valid/out_ready  accepted .. failure_count, one per input word
// cfg       to block   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word is processed at a time. Initialize, a tick that is early or precedes initialize,
// and a submit or clear refused up front go straight from accept to the finish state; the
// others sweep the slot memory through its single read port, one slot a cycle, and then
// enter the finish state. The finish state registers the result and returns to idle, where
// the next word is accepted; a stalled result holds the block until out_ready.
// Reset clears all control state and the slot valid bits; cfg_ready is always high.
`default_nettype none

module expiring_priority_request_arbiter_top #(
	parameter int SLOTS        = epra_pkg::DEF_SLOTS,
	parameter int PATTERN_BITS = epra_pkg::DEF_PATTERN_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        op,
	input  wire logic [epra_pkg::TIME_W-1:0]       now,
	input  wire logic [epra_pkg::OWNER_W-1:0]      owner,
	input  wire logic [epra_pkg::PRIO_W-1:0]       priority_req,
	input  wire logic [epra_pkg::PORT_PAT_W-1:0]   pattern,
	input  wire logic [epra_pkg::TIME_W-1:0]       expires_at,
	input  wire logic                              request_active,
	input  wire logic                              port_ok,

	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   accepted,
	output logic                                   applied,
	output logic      [epra_pkg::PORT_PAT_W-1:0]   applied_pattern,
	output logic      [epra_pkg::PRIO_W-1:0]       chosen_priority,
	output logic      [epra_pkg::OWNER_W-1:0]      chosen_owner,
	output logic                                   apply_ok,
	output logic      [epra_pkg::CNT_W-1:0]        success_count,
	output logic      [epra_pkg::CNT_W-1:0]        failure_count,

	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [epra_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [epra_pkg::CFG_DATA_W-1:0]   cfg_data
);

	`include "expiring_priority_request_arbiter_top_assert.svh"

	localparam int PW = PATTERN_BITS;
	localparam int OW = epra_pkg::OWNER_W;
	localparam int QW = epra_pkg::PRIO_W;
	localparam int TW = epra_pkg::TIME_W;
	localparam int NW = epra_pkg::CNT_W;
	localparam int XW = epra_pkg::EXT_W;
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int RW = TW + PW + QW + OW;

	// Configuration registers.
	logic [epra_pkg::INTERVAL_W-1:0] refresh_interval_q;
	logic [PW-1:0]                   off_pattern_q;
	logic [XW-1:0]                   cfg_ext;
	logic                            cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign cfg_ext   = XW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_interval_q <= epra_pkg::REFRESH_RESET;
			off_pattern_q      <= '0;
		end else if (cfg_fire) begin
			case (epra_pkg::cfg_reg_t'(cfg_index))
				epra_pkg::REG_REFRESH_INTERVAL: begin
					refresh_interval_q <= cfg_data[epra_pkg::INTERVAL_W-1:0];
				end
				epra_pkg::REG_OFF_PATTERN: begin
					off_pattern_q <= cfg_ext[PW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Captured input word.
	epra_pkg::op_t op_q;
	logic [TW-1:0] now_q;
	logic [OW-1:0] owner_q;
	logic [QW-1:0] prio_q;
	logic [PW-1:0] pat_q;
	logic [TW-1:0] exp_q;
	logic          port_q;
	logic          active_q;
	logic [XW-1:0] pattern_ext;

	assign pattern_ext = XW'(pattern);

	// Architectural state.
	logic [SLOTS-1:0] slot_vld_q;
	logic             ready_q;
	logic [TW-1:0]    next_refresh_q;
	logic [PW-1:0]    cur_pat_q;
	logic [QW-1:0]    cur_prio_q;
	logic [OW-1:0]    cur_owner_q;
	logic             last_ok_q;
	logic [NW-1:0]    good_q;
	logic [NW-1:0]    bad_q;

	// Sweep control and sweep results.
	epra_pkg::state_t state_q, state_d;
	logic [CW-1:0]    issue_cnt_q;
	logic             rd_vld_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic             hit_found_q, free_found_q, best_found_q;
	logic [IW-1:0]    hit_idx_q, free_idx_q;
	logic [QW-1:0]    best_prio_q;
	logic [OW-1:0]    best_owner_q;
	logic [PW-1:0]    best_pat_q;

	// Result register.
	logic          out_valid_q;
	logic          res_accepted_q, res_applied_q, res_ok_q;
	logic [PW-1:0] res_pat_q;
	logic [QW-1:0] res_prio_q;
	logic [OW-1:0] res_owner_q;
	logic [NW-1:0] res_good_q, res_bad_q;
	logic [XW-1:0] res_pat_ext;

	// Slot memory.
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic [OW-1:0] r_owner;
	logic [QW-1:0] r_prio;
	logic [PW-1:0] r_pat;
	logic [TW-1:0] r_exp;

	epra_ram #(
		.WIDTH(RW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(issue_cnt_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign ram_wdata = {exp_q, pat_q, prio_q, owner_q};
	assign r_owner   = ram_rdata[OW-1:0];
	assign r_prio    = ram_rdata[OW+QW-1:OW];
	assign r_pat     = ram_rdata[OW+QW+PW-1:OW+QW];
	assign r_exp     = ram_rdata[RW-1:OW+QW+PW];

	// Handshake and sweep events.
	logic in_fire, go_scan, scan_issue, scan_look, scan_done, finish_ld;
	logic slot_vld_rd, owner_eq, expired, better;
	logic slot_clr;

	assign in_ready    = (state_q == epra_pkg::ST_IDLE);
	assign in_fire     = in_valid & in_ready;
	assign scan_issue  = (state_q == epra_pkg::ST_SCAN) && (issue_cnt_q < CW'(SLOTS));
	assign scan_look   = (state_q == epra_pkg::ST_SCAN) && rd_vld_s1;
	assign scan_done   = scan_look && (rd_idx_s1 == IW'(SLOTS - 1));
	assign finish_ld   = (state_q == epra_pkg::ST_FINISH) && (!out_valid_q || out_ready);
	assign slot_vld_rd = slot_vld_q[rd_idx_s1];
	assign owner_eq    = (r_owner == owner_q);
	assign expired     = (r_exp <= now_q);
	assign better      = !best_found_q || (r_prio > best_prio_q) ||
			((r_prio == best_prio_q) && (r_owner < best_owner_q));
	assign slot_clr    = scan_look && slot_vld_rd &&
			(((op_q == epra_pkg::OP_CLEAR) && owner_eq) ||
			 ((op_q == epra_pkg::OP_TICK) && expired));

	// Decide at accept whether the word needs a sweep of the table.
	always_comb begin
		case (epra_pkg::op_t'(op))
			epra_pkg::OP_SUBMIT: go_scan = ready_q && request_active && (expires_at > now);
			epra_pkg::OP_CLEAR:  go_scan = (owner != '0);
			epra_pkg::OP_TICK:   go_scan = ready_q && (now >= next_refresh_q);
			default:             go_scan = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= epra_pkg::op_t'(op);
			now_q    <= now;
			owner_q  <= owner;
			prio_q   <= priority_req;
			pat_q    <= pattern_ext[PW-1:0];
			exp_q    <= expires_at;
			port_q   <= port_ok;
			active_q <= go_scan;
		end
	end

	// Next-state values committed when the result is registered.
	logic [TW:0]   refresh_sum;
	logic [TW-1:0] refresh_sat;
	logic          nx_ready, nx_ok, nx_accepted, nx_applied;
	logic [TW-1:0] nx_next_refresh;
	logic [PW-1:0] nx_pat;
	logic [QW-1:0] nx_prio;
	logic [OW-1:0] nx_owner;
	logic [NW-1:0] nx_good, nx_bad;

	assign refresh_sum = {1'b0, now_q} + (TW + 1)'(refresh_interval_q);
	assign refresh_sat = refresh_sum[TW] ? '1 : refresh_sum[TW-1:0];

	always_comb begin
		state_d         = state_q;
		nx_ready        = ready_q;
		nx_next_refresh = next_refresh_q;
		nx_pat          = cur_pat_q;
		nx_prio         = cur_prio_q;
		nx_owner        = cur_owner_q;
		nx_ok           = last_ok_q;
		nx_good         = good_q;
		nx_bad          = bad_q;
		nx_accepted     = 1'b0;
		nx_applied      = 1'b0;
		ram_we          = 1'b0;
		ram_waddr       = hit_found_q ? hit_idx_q : free_idx_q;

		case (state_q)
			epra_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = (go_scan && (epra_pkg::op_t'(op) != epra_pkg::OP_INIT)) ?
							epra_pkg::ST_SCAN : epra_pkg::ST_FINISH;
				end
			end
			epra_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = epra_pkg::ST_FINISH;
				end
			end
			epra_pkg::ST_FINISH: begin
				if (finish_ld) begin
					state_d = epra_pkg::ST_IDLE;
				end
				case (op_q)
					epra_pkg::OP_INIT: begin
						nx_ready        = port_q;
						nx_next_refresh = now_q;
						nx_pat          = port_q ? off_pattern_q : '0;
						nx_prio         = '0;
						nx_owner        = '0;
						nx_ok           = port_q;
						nx_good         = NW'(port_q);
						nx_bad          = '0;
						nx_accepted     = port_q;
						nx_applied      = port_q;
					end
					epra_pkg::OP_SUBMIT: begin
						nx_accepted = active_q && (hit_found_q || free_found_q);
						ram_we      = finish_ld && nx_accepted;
					end
					epra_pkg::OP_TICK: begin
						if (active_q) begin
							nx_pat          = best_found_q ? best_pat_q : off_pattern_q;
							nx_prio         = best_found_q ? best_prio_q : '0;
							nx_owner        = best_found_q ? best_owner_q : '0;
							nx_ok           = port_q;
							nx_good         = port_q ? good_q + NW'(1) : good_q;
							nx_bad          = port_q ? bad_q : bad_q + NW'(1);
							nx_next_refresh = refresh_sat;
							nx_applied      = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = epra_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sweep: a read is issued each cycle and its data is examined in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_cnt_q  <= '0;
			rd_vld_s1    <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (in_fire) begin
				issue_cnt_q  <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end else begin
				if (scan_issue) begin
					issue_cnt_q <= issue_cnt_q + CW'(1);
				end
				if (scan_look && (op_q == epra_pkg::OP_SUBMIT)) begin
					if (slot_vld_rd && owner_eq && !hit_found_q) begin
						hit_found_q <= 1'b1;
					end
					if (!slot_vld_rd && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
				if (scan_look && (op_q == epra_pkg::OP_TICK) && slot_vld_rd && !expired &&
						better) begin
					best_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_cnt_q[IW-1:0];
		if (scan_look && (op_q == epra_pkg::OP_SUBMIT)) begin
			if (slot_vld_rd && owner_eq && !hit_found_q) begin
				hit_idx_q <= rd_idx_s1;
			end
			if (!slot_vld_rd && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		if (scan_look && (op_q == epra_pkg::OP_TICK) && slot_vld_rd && !expired && better) begin
			best_prio_q  <= r_prio;
			best_owner_q <= r_owner;
			best_pat_q   <= r_pat;
		end
	end

	// Slot valid bits: a cleared slot counts as free until it is rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (finish_ld && (op_q == epra_pkg::OP_INIT)) begin
			slot_vld_q <= '0;
		end else if (ram_we) begin
			slot_vld_q[ram_waddr] <= 1'b1;
		end else if (slot_clr) begin
			slot_vld_q[rd_idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q        <= 1'b0;
			next_refresh_q <= '0;
			cur_pat_q      <= '0;
			cur_prio_q     <= '0;
			cur_owner_q    <= '0;
			last_ok_q      <= 1'b0;
			good_q         <= '0;
			bad_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (finish_ld) begin
				ready_q        <= nx_ready;
				next_refresh_q <= nx_next_refresh;
				cur_pat_q      <= nx_pat;
				cur_prio_q     <= nx_prio;
				cur_owner_q    <= nx_owner;
				last_ok_q      <= nx_ok;
				good_q         <= nx_good;
				bad_q          <= nx_bad;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish_ld) begin
			res_accepted_q <= nx_accepted;
			res_applied_q  <= nx_applied;
			res_pat_q      <= nx_pat;
			res_prio_q     <= nx_prio;
			res_owner_q    <= nx_owner;
			res_ok_q       <= nx_ok;
			res_good_q     <= nx_good;
			res_bad_q      <= nx_bad;
		end
	end

	assign res_pat_ext      = XW'(res_pat_q);
	assign out_valid        = out_valid_q;
	assign accepted         = res_accepted_q;
	assign applied          = res_applied_q;
	assign applied_pattern  = res_pat_ext[epra_pkg::PORT_PAT_W-1:0];
	assign chosen_priority  = res_prio_q;
	assign chosen_owner     = res_owner_q;
	assign apply_ok         = res_ok_q;
	assign success_count    = res_good_q;
	assign failure_count    = res_bad_q;

	`EPRA_ASSERT_SAME(a_ram_write_on_submit, ram_we,
		(state_q == epra_pkg::ST_FINISH) && (op_q == epra_pkg::OP_SUBMIT),
		"slot memory written outside a submit commit")
	`EPRA_ASSERT_SAME(a_issue_bound, state_q == epra_pkg::ST_SCAN,
		issue_cnt_q <= CW'(SLOTS), "sweep read counter ran past the table")
	`EPRA_ASSERT_NEXT(a_result_from_finish,
		!out_valid_q && !(state_q == epra_pkg::ST_FINISH), !out_valid_q,
		"result appeared without a commit")
	`EPRA_ASSERT_NEXT(a_counters_hold,
		finish_ld && !nx_applied && (op_q != epra_pkg::OP_INIT),
		$stable(good_q) && $stable(bad_q), "apply counters moved without an apply")

endmodule

`default_nettype wire

// ----- bench/expiring_priority_request_arbiter_top_tb.sv -----
module expiring_priority_request_arbiter_top_tb;
	import epra_pkg::*;

	localparam int NSLOT  = DEF_SLOTS;
	localparam int SETTLE = 16;
	localparam int DRAIN  = 40;
	localparam int LIMIT  = 500000;

	typedef struct packed {
		op_t         op;
		logic [31:0] now;
		logic [15:0] owner;
		logic [2:0]  prio;
		logic [31:0] pattern;
		logic [31:0] expires_at;
		logic        active;
		logic        port_ok;
	} led_request_t;

	typedef struct packed {
		logic        accepted;
		logic        applied;
		logic [31:0] pattern;
		logic [2:0]  prio;
		logic [15:0] owner;
		logic        ok;
		logic [31:0] good;
		logic [31:0] bad;
	} led_status_t;

	typedef struct {
		logic         is_setting;
		cfg_reg_t     setting_idx;
		logic [31:0]  setting_val;
		led_request_t req;
	} stim_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            op = OP_INIT;
	logic [TIME_W-1:0]     now = '0;
	logic [OWNER_W-1:0]    owner = '0;
	logic [PRIO_W-1:0]     priority_req = '0;
	logic [PORT_PAT_W-1:0] pattern = '0;
	logic [TIME_W-1:0]     expires_at = '0;
	logic                  request_active = 1'b0;
	logic                  port_ok = 1'b0;

	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  accepted;
	logic                  applied;
	logic [PORT_PAT_W-1:0] applied_pattern;
	logic [PRIO_W-1:0]     chosen_priority;
	logic [OWNER_W-1:0]    chosen_owner;
	logic                  apply_ok;
	logic [CNT_W-1:0]      success_count;
	logic [CNT_W-1:0]      failure_count;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the arbiter: slot table, current choice, counters and settings.
	logic        tbl_valid   [NSLOT] = '{default: 1'b0};
	logic [15:0] tbl_owner   [NSLOT] = '{default: '0};
	logic [2:0]  tbl_prio    [NSLOT] = '{default: '0};
	logic [31:0] tbl_pattern [NSLOT] = '{default: '0};
	logic [31:0] tbl_expiry  [NSLOT] = '{default: '0};
	logic        arb_ready = 1'b0;
	logic [31:0] arb_next_refresh = '0;
	logic [31:0] shown_pattern = '0;
	logic [2:0]  shown_prio = '0;
	logic [15:0] shown_owner = '0;
	logic        shown_ok = 1'b0;
	logic [31:0] good_cnt = '0;
	logic [31:0] bad_cnt = '0;
	logic [15:0] refresh_ms = REFRESH_RESET;
	logic [31:0] off_code = '0;

	stim_word_t  stim_q [$];
	led_status_t status_q [$];

	int   errors = 0;
	int   cycle_cnt = 0;
	int   quiet_cycles = 0;
	int   idle_gap = 0;
	int   burst_left = 8;
	int   stall_age = 0;
	logic [15:0] stall_pat = '1;
	logic in_took = 1'b0;
	logic cfg_took = 1'b0;

	expiring_priority_request_arbiter_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.now              (now),
		.owner            (owner),
		.priority_req     (priority_req),
		.pattern          (pattern),
		.expires_at       (expires_at),
		.request_active   (request_active),
		.port_ok          (port_ok),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.accepted         (accepted),
		.applied          (applied),
		.applied_pattern  (applied_pattern),
		.chosen_priority  (chosen_priority),
		.chosen_owner     (chosen_owner),
		.apply_ok         (apply_ok),
		.success_count    (success_count),
		.failure_count    (failure_count),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	function automatic void drop_slot(input int i);
		tbl_valid[i]   = 1'b0;
		tbl_owner[i]   = '0;
		tbl_prio[i]    = '0;
		tbl_pattern[i] = '0;
		tbl_expiry[i]  = '0;
	endfunction

	function automatic void record_apply(input logic [31:0] pat, input logic [2:0] prio,
			input logic [15:0] own, input logic ok);
		shown_pattern = pat;
		shown_prio    = prio;
		shown_owner   = own;
		shown_ok      = ok;
		if (ok) begin
			good_cnt++;
		end else begin
			bad_cnt++;
		end
	endfunction

	function automatic led_status_t arbitrate_request(input led_request_t r);
		led_status_t s;
		int hit;
		int best;
		logic [32:0] due;
		s = '0;
		hit = -1;
		best = -1;
		case (r.op)
			OP_INIT: begin
				for (int i = 0; i < NSLOT; i++) drop_slot(i);
				arb_ready = 1'b0;
				arb_next_refresh = r.now;
				shown_pattern = '0;
				shown_prio = '0;
				shown_owner = '0;
				shown_ok = 1'b0;
				good_cnt = '0;
				bad_cnt = '0;
				if (r.port_ok) begin
					arb_ready = 1'b1;
					record_apply(off_code, '0, '0, 1'b1);
					s.applied = 1'b1;
					s.accepted = 1'b1;
				end
			end
			OP_SUBMIT: begin
				if (arb_ready && r.active && r.expires_at > r.now) begin
					// An owner that already holds a slot keeps it; otherwise the lowest free one.
					for (int i = 0; i < NSLOT; i++)
						if (hit < 0 && tbl_valid[i] && tbl_owner[i] == r.owner) hit = i;
					for (int i = 0; i < NSLOT; i++)
						if (hit < 0 && !tbl_valid[i]) hit = i;
					if (hit >= 0) begin
						tbl_valid[hit]   = 1'b1;
						tbl_owner[hit]   = r.owner;
						tbl_prio[hit]    = r.prio;
						tbl_pattern[hit] = r.pattern;
						tbl_expiry[hit]  = r.expires_at;
						s.accepted = 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				if (r.owner != 0)
					for (int i = 0; i < NSLOT; i++)
						if (tbl_valid[i] && tbl_owner[i] == r.owner) drop_slot(i);
			end
			OP_TICK: begin
				if (arb_ready && r.now >= arb_next_refresh) begin
					for (int i = 0; i < NSLOT; i++)
						if (tbl_valid[i] && tbl_expiry[i] <= r.now) drop_slot(i);
					for (int i = 0; i < NSLOT; i++) begin
						if (tbl_valid[i]) begin
							if (best < 0) begin
								best = i;
							end else if (tbl_prio[i] > tbl_prio[best] ||
									(tbl_prio[i] == tbl_prio[best] &&
									tbl_owner[i] < tbl_owner[best])) begin
								best = i;
							end
						end
					end
					if (best >= 0) begin
						record_apply(tbl_pattern[best], tbl_prio[best], tbl_owner[best],
							r.port_ok);
					end else begin
						record_apply(off_code, '0, '0, r.port_ok);
					end
					s.applied = 1'b1;
					due = {1'b0, r.now} + 33'(refresh_ms);
					arb_next_refresh = due[32] ? 32'hFFFF_FFFF : due[31:0];
				end
			end
		endcase
		s.pattern = shown_pattern;
		s.prio    = shown_prio;
		s.owner   = shown_owner;
		s.ok      = shown_ok;
		s.good    = good_cnt;
		s.bad     = bad_cnt;
		return s;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic void queue_request(input op_t o, input logic [31:0] t,
			input logic [15:0] who, input logic [2:0] prio, input logic [31:0] pat,
			input logic [31:0] ex, input logic act, input logic port);
		stim_word_t w;
		w.is_setting = 1'b0;
		w.setting_idx = REG_REFRESH_INTERVAL;
		w.setting_val = '0;
		w.req = '{op: o, now: t, owner: who, prio: prio, pattern: pat, expires_at: ex,
			active: act, port_ok: port};
		stim_q.push_back(w);
	endfunction

	function automatic void queue_setting(input cfg_reg_t idx, input logic [31:0] val);
		stim_word_t w;
		w.is_setting = 1'b1;
		w.setting_idx = idx;
		w.setting_val = val;
		w.req = '0;
		stim_q.push_back(w);
	endfunction

	// Monitor: check result words, then fold accepted settings and requests into the shadow.
	always @(posedge clk) begin
		led_status_t want;
		led_request_t got_req;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					$error("Result word arrived with no request outstanding.");
					errors++;
				end else begin
					want = status_q.pop_front();
					check_field("accepted", want.accepted, accepted);
					check_field("applied", want.applied, applied);
					check_field("applied_pattern", want.pattern, applied_pattern);
					check_field("chosen_priority", want.prio, chosen_priority);
					check_field("chosen_owner", want.owner, chosen_owner);
					check_field("apply_ok", want.ok, apply_ok);
					check_field("success_count", want.good, success_count);
					check_field("failure_count", want.bad, failure_count);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_REFRESH_INTERVAL) begin
					refresh_ms = cfg_data[15:0];
				end else begin
					off_code = cfg_data;
				end
			end
			if (in_valid && in_ready) begin
				got_req = '{op: op_t'(op), now: now, owner: owner, prio: priority_req,
					pattern: pattern, expires_at: expires_at, active: request_active,
					port_ok: port_ok};
				status_q.push_back(arbitrate_request(got_req));
			end
		end
		in_took <= arst_n && in_valid && in_ready;
		cfg_took <= arst_n && cfg_valid && cfg_ready;
	end

	// Driver: request words go out in bursts; a setting waits until the arbiter is idle.
	always @(negedge clk) begin
		stim_word_t w;
		logic hold_in;
		logic hold_cfg;
		logic nv;
		logic ncv;
		hold_in = in_valid && !in_took;
		hold_cfg = cfg_valid && !cfg_took;
		nv = hold_in;
		ncv = hold_cfg;
		if (status_q.size() == 0 && !in_valid && !out_valid) begin
			quiet_cycles++;
		end else begin
			quiet_cycles = 0;
		end
		if (arst_n && !hold_in && !hold_cfg && stim_q.size() != 0) begin
			if (stim_q[0].is_setting) begin
				if (quiet_cycles >= SETTLE) begin
					w = stim_q.pop_front();
					cfg_index <= w.setting_idx;
					cfg_data <= w.setting_val;
					ncv = 1'b1;
				end
			end else if (idle_gap != 0) begin
				idle_gap--;
			end else begin
				w = stim_q.pop_front();
				op <= w.req.op;
				now <= w.req.now;
				owner <= w.req.owner;
				priority_req <= w.req.prio;
				pattern <= w.req.pattern;
				expires_at <= w.req.expires_at;
				request_active <= w.req.active;
				port_ok <= w.req.port_ok;
				nv = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					case ($urandom_range(0, 3))
						0: idle_gap = 0;
						1: idle_gap = $urandom_range(1, 3);
						2: idle_gap = $urandom_range(4, 30);
						default: idle_gap = 0;
					endcase
				end
			end
		end
		in_valid <= nv;
		cfg_valid <= ncv;
	end

	// Receiver: a rotating stall pattern, reselected now and then; never all stalls.
	always @(negedge clk) begin
		if (stall_age == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = '1;
				1: stall_pat = 16'($urandom) | 16'h8000;
				2: stall_pat = 16'($urandom & $urandom) | 16'h0001;
				default: stall_pat = 16'h0101;
			endcase
			stall_age = $urandom_range(16, 80);
		end else begin
			stall_pat = {stall_pat[0], stall_pat[15:1]};
			stall_age--;
		end
		out_ready <= stall_pat[0];
	end

	initial begin
		int r;
		logic [31:0] tm;
		logic [31:0] ex;
		logic [31:0] span;
		logic [15:0] who;
		logic [15:0] ivl;
		logic [31:0] offv;
		op_t o;

		// Directed words, run with the reset settings.
		queue_request(OP_SUBMIT, 32'd10, 16'd3, 3'd4, 32'h1234_5678, 32'd1000, 1'b1, 1'b1);
		queue_request(OP_TICK, 32'd10, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
		queue_request(OP_CLEAR, 32'd10, 16'd3, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
		queue_request(OP_INIT, 32'd20, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b0);
		queue_request(OP_SUBMIT, 32'd20, 16'd3, 3'd4, 32'h1234_5678, 32'd1000, 1'b1, 1'b1);
		queue_request(OP_INIT, 32'd0, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
		queue_request(OP_SUBMIT, 32'd5, 16'd9, 3'd5, 32'hDEAD_BEEF, 32'd900, 1'b0, 1'b1);
		queue_request(OP_SUBMIT, 32'd5, 16'd9, 3'd5, 32'hDEAD_BEEF, 32'd5, 1'b1, 1'b1);
		queue_request(OP_SUBMIT, 32'd5, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 1'b1);
		queue_request(OP_SUBMIT, 32'd5, 16'd1, 3'd7, 32'h0, 32'd500, 1'b1, 1'b1);
		// Equal priorities: the lower owner must win.
		queue_request(OP_TICK, 32'd5, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
		queue_request(OP_TICK, 32'd50, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
		queue_request(OP_SUBMIT, 32'd60, 16'd1, 3'd2, 32'hA5A5_A5A5, 32'd200, 1'b1, 1'b1);
		for (int k = 2; k < 8; k++)
			queue_request(OP_SUBMIT, 32'd60, 16'(k), 3'(k), 32'(k * 32'h1111_1111), 32'd150,
				1'b1, 1'b1);
		// The table is full now, so this word is turned away.
		queue_request(OP_SUBMIT, 32'd60, 16'd8, 3'd6, 32'h5A5A_5A5A, 32'd900, 1'b1, 1'b1);
		queue_request(OP_CLEAR, 32'd70, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
		queue_request(OP_CLEAR, 32'd70, 16'hFFFF, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
		queue_request(OP_TICK, 32'd300, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b0);
		queue_request(OP_TICK, 32'hFFFF_FFF0, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
		queue_request(OP_TICK, 32'hFFFF_FFFF, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);

		tm = 32'd1000;
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin ivl = 16'd0; offv = 32'hFFFF_FFFF; end
				1: begin ivl = 16'hFFFF; offv = 32'h0; end
				2: begin ivl = 16'd1; offv = $urandom; end
				3: begin ivl = 16'($urandom_range(20, 300)); offv = 32'hAAAA_5555; end
				9: begin ivl = REFRESH_RESET; offv = 32'h0; end
				default: begin ivl = 16'($urandom_range(0, 500)); offv = $urandom; end
			endcase
			if ($urandom_range(0, 1)) begin
				queue_setting(REG_REFRESH_INTERVAL, 32'(ivl));
				queue_setting(REG_OFF_PATTERN, offv);
			end else begin
				queue_setting(REG_OFF_PATTERN, offv);
				queue_setting(REG_REFRESH_INTERVAL, 32'(ivl));
			end
			span = 32'(ivl) + 32'd300;
			queue_request(OP_INIT, tm, 16'd0, 3'd0, 32'h0, 32'd0, 1'b0, 1'b1);
			for (int n = 0; n < 95; n++) begin
				r = $urandom_range(0, 99);
				if (r < 85) begin
					tm = tm + $urandom_range(0, span / 2);
				end else if (r < 94) begin
					tm = tm + $urandom_range(span, span * 10);
				end else if (r < 97) begin
					tm = $urandom;
				end else begin
					tm = 32'hFFFF_FFFF - $urandom_range(0, 2000);
				end
				r = $urandom_range(0, 99);
				if (r < 3) o = OP_INIT;
				else if (r < 48) o = OP_SUBMIT;
				else if (r < 60) o = OP_CLEAR;
				else o = OP_TICK;
				r = $urandom_range(0, 99);
				if (r < 80) who = 16'($urandom_range(1, 10));
				else if (r < 88) who = 16'd0;
				else if (r < 94) who = 16'hFFFF - 16'($urandom_range(0, 3));
				else who = 16'($urandom);
				r = $urandom_range(0, 99);
				if (r < 80) ex = tm + $urandom_range(1, span * 3);
				else if (r < 88) ex = tm - $urandom_range(0, 50);
				else if (r < 94) ex = 32'hFFFF_FFFF;
				else ex = $urandom;
				queue_request(o, tm, who, 3'($urandom_range(0, 7)), $urandom, ex,
					$urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && status_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		wait (cycle_cnt == LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
